// ===== rtl/fiss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fiss_pkg: shared types and constants of the FSK I/Q symbol slicer
// Widths of the sample path, symbol timing constants and register indexes.
// ---------------------------------------------------------------------------
package fiss_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int PROD_W    = 2 * SAMPLE_W;
	localparam int DISC_W    = PROD_W + 1;
	localparam int SUM_W     = 48;
	localparam int SPS_W     = 24;
	localparam int PHASE_W   = SPS_W + 1;
	localparam int BYTE_W    = 8;
	localparam int BIT_IDX_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = SPS_W;

	localparam logic [SPS_W-1:0] ONE_SAMPLE = 24'h01_0000;
	localparam logic [SPS_W-1:0] SPS_RESET  = 24'h04_0000;
	localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPS    = 2'd0,
		CFG_INVERT = 2'd1
	} cfg_index_t;

	typedef struct packed {
		logic              emit;
		logic [BYTE_W-1:0] byte_value;
	} slice_result_t;

endpackage

`default_nettype wire

// ===== rtl/fiss_slicer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fiss_slicer: discriminator accumulation, symbol timing and bit packing
// Holds the symbol sum, the Q9.16 timing phase and the partial byte.
// ---------------------------------------------------------------------------
module fiss_slicer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 take,
	input  wire logic signed [fiss_pkg::PROD_W-1:0]   prod_a,
	input  wire logic signed [fiss_pkg::PROD_W-1:0]   prod_b,
	input  wire logic        [fiss_pkg::SPS_W-1:0]    sym_period,
	input  wire logic                                 negate_disc,
	output fiss_pkg::slice_result_t                   result
);

	logic signed [fiss_pkg::SUM_W-1:0]     sum_q;
	logic        [fiss_pkg::PHASE_W-1:0]   phase_q;
	logic        [fiss_pkg::BYTE_W-1:0]    shift_q;
	logic        [fiss_pkg::BIT_IDX_W-1:0] bit_index_q;

	logic signed [fiss_pkg::DISC_W-1:0]    disc_raw;
	logic signed [fiss_pkg::DISC_W-1:0]    disc;
	logic signed [fiss_pkg::SUM_W-1:0]     sum_nx;
	logic        [fiss_pkg::SPS_W-1:0]     period;
	logic        [fiss_pkg::PHASE_W-1:0]   phase_inc;
	logic                                  slice;
	logic                                  bit_val;
	logic        [fiss_pkg::BYTE_W-1:0]    shift_nx;

	always_comb begin
		disc_raw = $signed({prod_a[fiss_pkg::PROD_W-1], prod_a})
			- $signed({prod_b[fiss_pkg::PROD_W-1], prod_b});
		disc = negate_disc ? -disc_raw : disc_raw;
		sum_nx = sum_q + {{(fiss_pkg::SUM_W - fiss_pkg::DISC_W){disc[fiss_pkg::DISC_W-1]}}, disc};
		// a period below one sample acts as one sample
		period = (sym_period < fiss_pkg::ONE_SAMPLE) ? fiss_pkg::ONE_SAMPLE
			: sym_period;
		phase_inc = phase_q + {1'b0, fiss_pkg::ONE_SAMPLE};
		slice = (phase_inc >= {1'b0, period});
		bit_val = ~sum_nx[fiss_pkg::SUM_W-1];
		shift_nx = shift_q | (fiss_pkg::BYTE_W'(bit_val) << bit_index_q);
		result.emit = take && slice && (bit_index_q == fiss_pkg::LAST_BIT);
		result.byte_value = shift_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			phase_q     <= '0;
			shift_q     <= '0;
			bit_index_q <= '0;
		end else if (take) begin
			if (slice) begin
				sum_q       <= '0;
				phase_q     <= phase_inc - {1'b0, period};
				bit_index_q <= bit_index_q + 1'b1;
				shift_q     <= (bit_index_q == fiss_pkg::LAST_BIT) ? '0 : shift_nx;
			end else begin
				sum_q   <= sum_nx;
				phase_q <= phase_inc;
			end
		end
	end

	a_emit_only_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		result.emit |-> take && slice)
		else $error("byte emitted without a symbol decision");

	a_byte_clears: assert property (@(posedge clk) disable iff (!arst_n)
		result.emit |=> shift_q == '0 && bit_index_q == '0)
		else $error("bit packer not cleared after a byte");

	a_phase_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		(take && slice && $stable(sym_period)
			&& phase_inc < {1'b0, period} + {1'b0, period})
		|=> phase_q < {1'b0, $past(period)})
		else $error("timing phase left at or above the period");

endmodule

`default_nettype wire

// ===== rtl/fsk_iq_symbol_slicer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fsk_iq_symbol_slicer_unit: differential-phase FSK demodulator and slicer
//
// Input channel (in_valid / in_stall) takes one signed I/Q sample pair per
// request. The first pair after reset only primes the previous-sample store.
// Each later pair forms I*Qprev - Q*Iprev, which is summed over a symbol;
// a Q9.16 phase counter advancing by 1.0 per pair decides when a symbol ends,
// and the sum's sign (zero counts as positive) gives one bit, packed LSB
// first. Every eighth bit leaves on the output channel (out_valid /
// out_stall) as byte_value.
// Throughput: one pair per cycle unless the output stalls, set by the
// three-register pipeline (input register, product register, output
// register). The slicer feeds the output register from the product register.
// A stalled output holds its byte; pairs keep entering until the pipeline
// behind the output register is full, then in_stall rises. Reset clears the
// pipeline and all symbol state and loads the registers with 4.0 samples per
// symbol and no inversion. Registers are written via cfg_write / cfg_index /
// cfg_data, by the user only while the block is idle; it is not checked.
// ---------------------------------------------------------------------------
module fsk_iq_symbol_slicer_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic        [fiss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [fiss_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [fiss_pkg::SAMPLE_W-1:0] i_sample,
	input  wire logic signed [fiss_pkg::SAMPLE_W-1:0] q_sample,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic             [fiss_pkg::BYTE_W-1:0]   byte_value
);

	logic [fiss_pkg::SPS_W-1:0] sps_q;
	logic                       invert_q;

	logic                                 valid_s1;
	logic signed [fiss_pkg::SAMPLE_W-1:0] i_s1;
	logic signed [fiss_pkg::SAMPLE_W-1:0] q_s1;
	logic signed [fiss_pkg::SAMPLE_W-1:0] prev_i_q;
	logic signed [fiss_pkg::SAMPLE_W-1:0] prev_q_q;
	logic                                 have_prev_q;

	logic                                 valid_s2;
	logic signed [fiss_pkg::PROD_W-1:0]   prod_a_s2;
	logic signed [fiss_pkg::PROD_W-1:0]   prod_b_s2;

	logic                    out_valid_q;
	logic [fiss_pkg::BYTE_W-1:0] byte_q;

	logic                    out_free;
	logic                    take;
	logic                    load_s2;
	logic                    load_s1;
	fiss_pkg::slice_result_t slice_res;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q    <= fiss_pkg::SPS_RESET;
			invert_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (fiss_pkg::cfg_index_t'(cfg_index))
				fiss_pkg::CFG_SPS:    sps_q    <= cfg_data;
				fiss_pkg::CFG_INVERT: invert_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// elastic pipeline control: each stage moves when the next one has room
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		take     = valid_s2 && out_free;
		load_s2  = !valid_s2 || take;
		load_s1  = !valid_s1 || load_s2;
		in_stall = !load_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			i_s1 <= i_sample;
			q_s1 <= q_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_i_q    <= '0;
			prev_q_q    <= '0;
			have_prev_q <= 1'b0;
			valid_s2    <= 1'b0;
		end else if (load_s2) begin
			// the first pair only primes the previous-sample store
			valid_s2 <= valid_s1 && have_prev_q;
			if (valid_s1) begin
				prev_i_q    <= i_s1;
				prev_q_q    <= q_s1;
				have_prev_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			prod_a_s2 <= fiss_pkg::PROD_W'(i_s1) * fiss_pkg::PROD_W'(prev_q_q);
			prod_b_s2 <= fiss_pkg::PROD_W'(q_s1) * fiss_pkg::PROD_W'(prev_i_q);
		end
	end

	fiss_slicer u_slicer (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.prod_a      (prod_a_s2),
		.prod_b      (prod_b_s2),
		.sym_period  (sps_q),
		.negate_disc (invert_q),
		.result      (slice_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= slice_res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (slice_res.emit) begin
			byte_q <= slice_res.byte_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_value = byte_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		slice_res.emit |-> !(out_valid_q && out_stall))
		else $error("byte produced while the output register is held");

	a_prime_only: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !have_prev_q && load_s2) |=> !valid_s2 && have_prev_q)
		else $error("priming pair reached the accumulator");

	a_prev_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		have_prev_q |=> have_prev_q)
		else $error("previous-sample flag dropped");

	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> valid_s2)
		else $error("accumulator advanced without a product pair");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the FSK I/Q symbol slicer
// Streams sample pairs over the valid/stall input. A behavioral demodulator
// predicts every sliced byte, and the output monitor checks each byte in
// order. Symbol period and inversion are swept between traffic phases.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int SAMPLE_W  = fiss_pkg::SAMPLE_W;
	localparam int CFG_IDX_W = fiss_pkg::CFG_IDX_W;
	localparam int CFG_W     = fiss_pkg::CFG_W;
	localparam int BYTE_W    = fiss_pkg::BYTE_W;
	localparam int SPS_W     = fiss_pkg::SPS_W;
	localparam int PHASE_W   = fiss_pkg::PHASE_W;
	localparam int SUM_W     = fiss_pkg::SUM_W;
	localparam int BIT_IDX_W = fiss_pkg::BIT_IDX_W;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 64;
	localparam int NUM_PHASES   = 10;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] i;
		logic signed [SAMPLE_W-1:0] q;
	} iq_pair_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] i_sample  = '0;
	logic signed [SAMPLE_W-1:0] q_sample  = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [BYTE_W-1:0]          byte_value;

	fsk_iq_symbol_slicer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.i_sample   (i_sample),
		.q_sample   (q_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.byte_value (byte_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	iq_pair_t          pairs_to_send [$];
	logic [BYTE_W-1:0] bytes_due [$];
	int                mismatches    = 0;
	int                idle_cycles   = 0;
	bit                pair_taken    = 1'b0;
	bit                calm          = 1'b0;
	bit                long_hold_req = 1'b0;

	// demodulator state and register copies
	logic [SPS_W-1:0]           sps_mirror;
	logic                       invert_mirror;
	logic signed [SAMPLE_W-1:0] last_i, last_q;
	logic                       primed;
	logic [PHASE_W-1:0]         sym_phase;
	logic [SUM_W-1:0]           disc_sum;
	logic [BYTE_W-1:0]          bits_acc;
	logic [BIT_IDX_W-1:0]       bits_held;

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("ERROR at %0t: %s", $time, what);
	endtask

	task automatic slice_pair(input logic signed [SAMPLE_W-1:0] si,
			input logic signed [SAMPLE_W-1:0] sq);
		longint             disc;
		logic [PHASE_W-1:0] period;
		if (!primed) begin
			last_i = si;
			last_q = sq;
			primed = 1'b1;
			return;
		end
		disc = longint'(si) * longint'(last_q) - longint'(sq) * longint'(last_i);
		last_i = si;
		last_q = sq;
		if (invert_mirror)
			disc = -disc;
		disc_sum = disc_sum + disc[SUM_W-1:0];
		// periods under one sample act as exactly one sample
		period = (sps_mirror < fiss_pkg::ONE_SAMPLE) ? {1'b0, fiss_pkg::ONE_SAMPLE}
			: {1'b0, sps_mirror};
		sym_phase = sym_phase + {1'b0, fiss_pkg::ONE_SAMPLE};
		if (sym_phase >= period) begin
			bits_acc[bits_held] = ~disc_sum[SUM_W-1];
			sym_phase = sym_phase - period;
			disc_sum = '0;
			if (bits_held == fiss_pkg::LAST_BIT) begin
				bytes_due.push_back(bits_acc);
				bits_acc = '0;
				bits_held = '0;
			end else begin
				bits_held = bits_held + 1'b1;
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] corner_value(input int k);
		case (k)
			0: return S_MIN;
			1: return S_MIN + 16'sd1;
			2: return -16'sd1;
			3: return '0;
			4: return 16'sd1;
			5: return S_MAX - 16'sd1;
			default: return S_MAX;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input int v);
		if (v > int'(S_MAX))
			return S_MAX;
		if (v < int'(S_MIN))
			return S_MIN;
		return SAMPLE_W'(v);
	endfunction

	task automatic queue_pair(input logic signed [SAMPLE_W-1:0] si,
			input logic signed [SAMPLE_W-1:0] sq);
		iq_pair_t p;
		p.i = si;
		p.q = sq;
		pairs_to_send.push_back(p);
	endtask

	// mostly rotating phasors held in one direction for a run of samples,
	// mixed with raw noise, corner values and repeated samples
	task automatic queue_random_pairs(input int n);
		int                         mode, run_left, quad, amp, dir, ci, cq, k;
		logic signed [SAMPLE_W-1:0] ri, rq;
		run_left = 0;
		quad = 0;
		amp = 1;
		dir = 1;
		mode = 0;
		ri = '0;
		rq = '0;
		for (k = 0; k < n; k++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(1, 12);
				mode = $urandom_range(0, 9);
				dir = $urandom_range(0, 1) ? 1 : -1;
				amp = $urandom_range(1, 32767);
			end
			run_left--;
			if (mode < 6) begin
				quad = (quad + dir) & 3;
				ci = (quad == 0) ? amp : (quad == 2) ? -amp : 0;
				cq = (quad == 1) ? amp : (quad == 3) ? -amp : 0;
				ri = clamp_sample(ci + int'($urandom_range(0, 64)) - 32);
				rq = clamp_sample(cq + int'($urandom_range(0, 64)) - 32);
			end else if (mode < 8) begin
				ri = SAMPLE_W'($urandom);
				rq = SAMPLE_W'($urandom);
			end else if (mode == 8) begin
				ri = corner_value($urandom_range(0, 6));
				rq = corner_value($urandom_range(0, 6));
			end
			// repeat mode keeps the last sample: zero discriminator
			queue_pair(ri, rq);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pairs_to_send.size() != 0 || in_valid || bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// input driver
	int       send_gap = 0;
	iq_pair_t next_pair;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !pair_taken) begin
			// hold the stalled request
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (pairs_to_send.size() != 0) begin
			next_pair = pairs_to_send.pop_front();
			i_sample <= next_pair.i;
			q_sample <= next_pair.q;
			in_valid <= 1'b1;
			send_gap = calm ? 0 : pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// output stall generator
	int stall_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			stall_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left = calm ? 0 : pick_gap();
		end
	end

	// monitor: register writes, accepted pairs, delivered bytes
	logic [BYTE_W-1:0] want_byte;
	always @(posedge clk) begin
		pair_taken = 1'b0;
		if (!arst_n) begin
			sps_mirror = fiss_pkg::SPS_RESET;
			invert_mirror = 1'b0;
			last_i = '0;
			last_q = '0;
			primed = 1'b0;
			sym_phase = '0;
			disc_sum = '0;
			bits_acc = '0;
			bits_held = '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					fiss_pkg::CFG_SPS:    sps_mirror = cfg_data;
					fiss_pkg::CFG_INVERT: invert_mirror = cfg_data[0];
					default:    ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (bytes_due.size() == 0) begin
					flag_mismatch($sformatf("byte %02h with none expected", byte_value));
				end else begin
					want_byte = bytes_due.pop_front();
					if (byte_value !== want_byte)
						flag_mismatch($sformatf("byte_value %02h, expected %02h",
							byte_value, want_byte));
				end
			end
			if (in_valid && !in_stall) begin
				pair_taken = 1'b1;
				slice_pair(i_sample, q_sample);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no traffic for %0d cycles", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int               ph, k, n;
		logic [SPS_W-1:0] sps;
		logic             inv;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corner samples under the reset settings; all-zero symbol slices a one
		@(posedge clk);
		queue_pair(S_MIN, S_MIN);
		repeat (4) queue_pair('0, '0);
		for (k = 0; k < 7; k++) begin
			queue_pair(corner_value(k), corner_value(6 - k));
			queue_pair(corner_value(6 - k), corner_value(k));
		end
		wait_drained();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin sps = fiss_pkg::ONE_SAMPLE; inv = 1'b0; n = 220; end
				1: begin sps = '0;           inv = 1'b1; n = 150; end
				2: begin sps = 24'h00_ffff;  inv = 1'b0; n = 100; end
				3: begin sps = 24'h01_8000;  inv = 1'b1; n = 150; end
				4: begin sps = 24'hff_ffff;  inv = 1'b0; n = 300; end
				// shortened period leaves the phase far above it
				5: begin sps = fiss_pkg::ONE_SAMPLE; inv = 1'b1; n = 150; end
				6: begin sps = 24'h03_4000;  inv = 1'b0; n = 150; end
				9: begin sps = 24'h08_0000;  inv = 1'b1; n = 150; end
				default: begin
					sps = SPS_W'($urandom_range(65536, 600000));
					inv = 1'($urandom_range(0, 1));
					n = 200;
				end
			endcase
			write_reg(fiss_pkg::CFG_SPS, sps);
			write_reg(fiss_pkg::CFG_INVERT, {{(CFG_W-1){1'b0}}, inv});
			// spare indexes must leave both registers alone
			write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_W'($urandom));
			@(posedge clk);
			calm = (ph == 0) || ($urandom_range(0, 3) == 0);
			if (ph == 0)
				long_hold_req = 1'b1;
			queue_random_pairs(n);
			wait_drained();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== fsk_iq_symbol_slicer_unit.f =====
rtl/fiss_pkg.sv
rtl/fiss_slicer.sv
rtl/fsk_iq_symbol_slicer_unit.sv
tb/tb_top.sv
